/* design/assert_macros.svh */
// Assertion macros used by the checker file.
// Depends on nothing; the including module must declare clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* design/tldacc_pkg.sv */
// Types, codes and constants for the tape loader detect / accelerate unit.
// Used by tldacc_core and the top level; depends on nothing.
`default_nettype none

package tldacc_pkg;

    // Item kinds on the input tuser
    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_FRAME = 2'd1,
        CMD_EDGE  = 2'd2,
        CMD_PLAY  = 2'd3
    } cmd_e;

    // Configuration register indexes
    localparam logic [1:0] CFG_DETECT_ENABLE     = 2'd0;
    localparam logic [1:0] CFG_ACCELERATE_ENABLE = 2'd1;
    localparam logic [1:0] CFG_RECORDING_ACTIVE  = 2'd2;

    // Detection windows and thresholds
    localparam logic [31:0] PLAY_WINDOW    = 32'd1000;
    localparam logic [31:0] STOPPED_WINDOW = 32'd500;
    localparam logic [7:0]  LOADER_READS   = 8'd10;
    localparam logic [7:0]  MOVIE_READS    = 8'd128;
    localparam logic [7:0]  STOP_READS     = 8'd10;
    localparam logic [7:0]  COUNT_MAX      = 8'hff;
    localparam logic [7:0]  BDIFF_DOWN     = 8'hff;
    localparam logic [2:0]  MODE_MAX       = 3'd5;
    // Time stamp meaning "no read seen yet" (-100000)
    localparam logic [31:0] NEVER_READ     = 32'hfffe7960;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 8;

    typedef struct packed {
        cmd_e        command;
        logic [19:0] time_now;
        logic [7:0]  b_value;
        logic [15:0] instr_addr;
        logic        loop_match;
        logic        movie_match;
        logic        ear_match;
        logic [2:0]  detected_mode;
        logic        tape_playing;
        logic [16:0] frame_span;
        logic [1:0]  edge_length;
        logic        edge_by_accel;
    } in_item_t;

    typedef struct packed {
        logic        stop_tape;
        logic        start_tape;
        logic        accel_apply;
        logic [2:0]  accel_mode_out;
        logic        accel_long;
    } out_item_t;

    typedef struct packed {
        logic detect_enable;
        logic accelerate_enable;
        logic recording_active;
    } cfg_t;

    // Split the stream words into the item fields
    function automatic in_item_t unpack_item(input logic [1:0] user,
                                             input logic [IN_TDATA_W-1:0] data);
        in_item_t it;
        it.command       = cmd_e'(user);
        it.time_now      = data[19:0];
        it.b_value       = data[27:20];
        it.instr_addr    = data[43:28];
        it.loop_match    = data[44];
        it.movie_match   = data[45];
        it.ear_match     = data[46];
        it.detected_mode = data[49:47];
        it.tape_playing  = data[50];
        it.frame_span    = data[67:51];
        it.edge_length   = data[69:68];
        it.edge_by_accel = data[70];
        return it;
    endfunction

    function automatic logic [OUT_TDATA_W-1:0] pack_result(input out_item_t r);
        return {1'b0, r.accel_long, r.accel_mode_out, r.accel_apply,
                r.start_tape, r.stop_tape};
    endfunction

endpackage

`default_nettype wire

/* design/tldacc_core.sv */
// Detection and acceleration state with its single-pass update logic.
// Depends on tldacc_pkg.
`default_nettype none

module tldacc_core
    import tldacc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cfg_t      cfg,
    input  wire in_item_t  item,
    input  wire logic      fire,
    output out_item_t      res
);

    logic [7:0]  cnt_reg,   cnt_next;
    logic [31:0] lrt_reg,   lrt_next;
    logic [7:0]  last_b_reg, last_b_next;
    logic        cur_known_reg, cur_known_next;
    logic        cur_long_reg,  cur_long_next;
    logic        nxt_known_reg, nxt_known_next;
    logic        nxt_long_reg,  nxt_long_next;
    logic [2:0]  mode_reg,  mode_next;
    logic [15:0] addr_reg,  addr_next;

    logic [2:0]  dmode;
    logic [31:0] tdiff;
    logic [7:0]  bdiff;
    logic [7:0]  cnt_inc;
    logic [7:0]  need;
    logic        playing;
    logic        plausible;
    logic [2:0]  mode_cur;

    // Shared arithmetic on the current read
    assign dmode   = (item.detected_mode > MODE_MAX) ? 3'd0 : item.detected_mode;
    assign tdiff   = {12'd0, item.time_now} - lrt_reg;
    assign bdiff   = item.b_value - last_b_reg;
    assign cnt_inc = (cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + 8'd1;
    assign plausible = (tdiff <= PLAY_WINDOW) &&
                       (bdiff == 8'd1 || bdiff == 8'd0 || bdiff == BDIFF_DOWN);

    // Threshold a stopped tape needs before starting
    always_comb
    begin
        if (item.movie_match && tdiff <= STOPPED_WINDOW)
            need = MOVIE_READS;
        else if (item.loop_match)
            need = LOADER_READS;
        else if (item.ear_match && tdiff <= STOPPED_WINDOW &&
                 (bdiff == 8'd1 || bdiff == BDIFF_DOWN))
            need = LOADER_READS;
        else
            need = 8'd0;
    end

    // Next state and result for one item
    always_comb
    begin
        cnt_next       = cnt_reg;
        lrt_next       = lrt_reg;
        last_b_next    = last_b_reg;
        cur_known_next = cur_known_reg;
        cur_long_next  = cur_long_reg;
        nxt_known_next = nxt_known_reg;
        nxt_long_next  = nxt_long_reg;
        mode_next      = mode_reg;
        addr_next      = addr_reg;
        playing        = item.tape_playing;
        mode_cur       = 3'd0;
        res            = '0;

        unique case (item.command)
            CMD_FRAME:
            begin
                if ($signed(lrt_reg) > $signed(NEVER_READ))
                    lrt_next = lrt_reg - {15'd0, item.frame_span};
            end
            CMD_EDGE:
            begin
                // Low bit (short) wins over high bit (long)
                if (item.edge_length[0])
                begin
                    nxt_known_next = 1'b1;
                    nxt_long_next  = 1'b0;
                end
                else if (item.edge_length[1])
                begin
                    nxt_known_next = 1'b1;
                    nxt_long_next  = 1'b1;
                end
                else
                    nxt_known_next = 1'b0;
                if (!item.edge_by_accel)
                    cur_known_next = 1'b0;
            end
            CMD_PLAY:
            begin
                cnt_next  = 8'd0;
                mode_next = 3'd0;
            end
            CMD_READ:
            begin
                lrt_next    = {12'd0, item.time_now};
                last_b_next = item.b_value;

                // Start / stop detection
                if (!cfg.detect_enable)
                    cnt_next = 8'd0;
                else if (item.tape_playing)
                begin
                    if (item.loop_match || item.movie_match || item.ear_match || plausible)
                        cnt_next = 8'd0;
                    else if (cnt_inc >= STOP_READS)
                    begin
                        res.stop_tape = 1'b1;
                        playing       = 1'b0;
                        cnt_next      = 8'd0;
                        mode_next     = 3'd0;
                    end
                    else
                        cnt_next = cnt_inc;
                end
                else
                begin
                    if (need == 8'd0)
                        cnt_next = 8'd0;
                    else if (cnt_inc >= need)
                    begin
                        res.start_tape = 1'b1;
                        playing        = 1'b1;
                        cnt_next       = 8'd0;
                        mode_next      = 3'd0;
                    end
                    else
                        cnt_next = cnt_inc;
                end

                // Edge-loop acceleration, bound to one instruction address
                if (cfg.accelerate_enable && playing && !cfg.recording_active)
                begin
                    mode_cur = mode_next;
                    if (mode_cur != 3'd0 && item.instr_addr != addr_reg)
                        mode_cur = 3'd0;
                    if (mode_cur == 3'd0)
                    begin
                        mode_cur  = dmode;
                        addr_next = item.instr_addr;
                    end
                    mode_next = mode_cur;
                    if (mode_cur != 3'd0)
                    begin
                        if (cur_known_reg)
                        begin
                            res.accel_apply    = 1'b1;
                            res.accel_mode_out = mode_cur;
                            res.accel_long     = cur_long_reg;
                            cnt_next           = 8'd0;
                        end
                        cur_known_next = nxt_known_reg;
                        cur_long_next  = nxt_long_reg;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // State registers, updated once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= 8'd0;
            lrt_reg       <= NEVER_READ;
            last_b_reg    <= 8'd0;
            cur_known_reg <= 1'b0;
            cur_long_reg  <= 1'b0;
            nxt_known_reg <= 1'b0;
            nxt_long_reg  <= 1'b0;
            mode_reg      <= 3'd0;
            addr_reg      <= 16'd0;
        end
        else if (fire)
        begin
            cnt_reg       <= cnt_next;
            lrt_reg       <= lrt_next;
            last_b_reg    <= last_b_next;
            cur_known_reg <= cur_known_next;
            cur_long_reg  <= cur_long_next;
            nxt_known_reg <= nxt_known_next;
            nxt_long_reg  <= nxt_long_next;
            mode_reg      <= mode_next;
            addr_reg      <= addr_next;
        end
    end

endmodule

`default_nettype wire

/* design/tape_loader_detect_accelerate_unit.sv */
// Tape loader detect / accelerate unit: input register, core, result register.
// Path: input register, core, result register; the result register drives m_tvalid.
// Throughput: one item per cycle while m_tready does not stall the result register.
// While a result waits, the input stage takes one more item, then s_tready drops.
// Reset (rst_n low, asynchronous): both stages empty, config to detect=1,
// accelerate=1, recording=0, and all detection state to its idle values.
`default_nettype none

module tape_loader_detect_accelerate_unit
    import tldacc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Configuration write port
    input  wire logic                   cfg_wr_en,
    input  wire logic [1:0]             cfg_index,
    input  wire logic                   cfg_data,
    // Input stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // s_tdata: time_now[19:0], b_value[27:20], instr_addr[43:28], loop_match[44],
    // movie_match[45], ear_match[46], detected_mode[49:47], tape_playing[50],
    // frame_span[67:51], edge_length[69:68], edge_by_accel[70], zero[71]
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // s_tuser: command[1:0]
    input  wire logic [1:0]             s_tuser,
    // Result stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // m_tdata: stop_tape[0], start_tape[1], accel_apply[2], accel_mode_out[5:3],
    // accel_long[6], zero[7]
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    cfg_t      cfg_reg;
    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t core_res;
    logic      fire;

    // Core consumes the held item when the result register is empty or being read
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = pack_result(out_item_reg);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.detect_enable     <= 1'b1;
            cfg_reg.accelerate_enable <= 1'b1;
            cfg_reg.recording_active  <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == CFG_DETECT_ENABLE)
                cfg_reg.detect_enable <= cfg_data;
            if (cfg_index == CFG_ACCELERATE_ENABLE)
                cfg_reg.accelerate_enable <= cfg_data;
            if (cfg_index == CFG_RECORDING_ACTIVE)
                cfg_reg.recording_active <= cfg_data;
        end
    end

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_item_reg <= unpack_item(s_tuser, s_tdata);
        if (fire)
            out_item_reg <= core_res;
    end

    tldacc_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .item  (in_item_reg),
        .fire  (fire),
        .res   (core_res)
    );

endmodule

`default_nettype wire

/* design/tldacc_checker.sv */
// Port-level checks for the tape loader detect / accelerate unit, with bind.
// Depends on assert_macros.svh and tape_loader_detect_accelerate_unit.
`default_nettype none
`include "assert_macros.svh"

module tldacc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);

    // A read never both starts and stops the tape
    `ASSERT_IMPL(a_no_start_and_stop, m_tvalid, !(m_tdata[0] && m_tdata[1]))

    // Mode and length are zero without an apply strobe
    `ASSERT_IMPL(a_idle_fields_zero, m_tvalid && !m_tdata[2], m_tdata[6:3] == 4'd0)

    // An applied mode is a real one
    `ASSERT_IMPL(a_apply_mode_valid, m_tvalid && m_tdata[2],
                 m_tdata[5:3] != 3'd0 && m_tdata[5:3] <= 3'd5)

    // A stalled result holds
    `ASSERT_NEXT(a_result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind tape_loader_detect_accelerate_unit tldacc_checker u_tldacc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

/* sim/tb.sv */
// Self-checking bench for tape_loader_detect_accelerate_unit: directed and random
// port-read, frame, edge and play transfers checked against a built-in predictor.
// Depends on tldacc_pkg and the unit's RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tldacc_pkg::*;

    // Detection windows and thresholds used by the predictor
    localparam logic [31:0] PLAY_TDIFF_MAX     = 32'd1000;
    localparam logic [31:0] STOP_TDIFF_MAX     = 32'd500;
    localparam logic [7:0]  LOADER_START_READS = 8'd10;
    localparam logic [7:0]  MOVIE_START_READS  = 8'd128;
    localparam logic [7:0]  NON_EAR_STOP_READS = 8'd10;
    localparam logic [7:0]  READ_COUNT_SAT     = 8'd255;
    localparam logic [7:0]  B_DOWN             = 8'hff;
    localparam logic [2:0]  MODE_LIMIT         = 3'd5;
    localparam int          NO_READ_TIME       = -100000;

    localparam int          FRAME_TSTATES      = 69888;
    localparam int          ITEMS_PER_PHASE    = 244;
    localparam int          HOLD_CYCLES        = 300;
    localparam int unsigned CYCLE_LIMIT        = 400000;

    // Per-phase register settings, phase 0 first
    localparam bit [0:7] DET_BY_PHASE = 8'b11101011;
    localparam bit [0:7] ACC_BY_PHASE = 8'b11110011;
    localparam bit [0:7] REC_BY_PHASE = 8'b00100000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [1:0]            cfg_index;
    logic                  cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_TDATA_W-1:0] s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    tape_loader_detect_accelerate_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Predictor state and register copies
    logic [7:0]  reads_seen;
    logic [31:0] last_time;
    logic [7:0]  last_b;
    logic        cur_known, cur_long, nxt_known, nxt_long;
    logic [2:0]  accel_mode_q;
    logic [15:0] accel_pc;
    logic        det_en, acc_en, rec_on;

    // Stimulus generator state
    int unsigned gen_t;
    logic [7:0]  gen_b;

    in_item_t    pending_items[$];
    out_item_t   expected_decisions[$];
    in_item_t    offered_item;
    int          n_pushed;
    int          n_accepted;
    int          errors;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_req;
    int          hold_left;
    bit          s_taken;
    int unsigned cycle_count;

    // Clock, 20 ns period
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Next tape start/stop and acceleration decision for one transfer
    function automatic out_item_t tape_decision(input in_item_t it);
        out_item_t   r;
        logic [31:0] tdiff;
        logic [7:0]  bdiff;
        logic [2:0]  dm;
        logic        play;
        logic [7:0]  need;
        r = '0;
        dm = (it.detected_mode > MODE_LIMIT) ? 3'd0 : it.detected_mode;
        play = it.tape_playing;
        case (it.command)
            CMD_FRAME:
            begin
                // rebase only once a read has been seen
                if ($signed(last_time) > NO_READ_TIME)
                    last_time = last_time - {15'd0, it.frame_span};
            end
            CMD_EDGE:
            begin
                // short wins when both length bits are set
                if (it.edge_length[0])
                begin
                    nxt_known = 1'b1;
                    nxt_long = 1'b0;
                end
                else if (it.edge_length[1])
                begin
                    nxt_known = 1'b1;
                    nxt_long = 1'b1;
                end
                else
                    nxt_known = 1'b0;
                if (!it.edge_by_accel)
                    cur_known = 1'b0;
            end
            CMD_PLAY:
            begin
                reads_seen = '0;
                accel_mode_q = '0;
            end
            CMD_READ:
            begin
                tdiff = {12'd0, it.time_now} - last_time;
                bdiff = it.b_value - last_b;
                last_time = {12'd0, it.time_now};
                last_b = it.b_value;
                if (!det_en)
                    reads_seen = '0;
                else if (play)
                begin
                    // non-loader reads while playing count toward a stop
                    if (it.loop_match || it.movie_match || it.ear_match ||
                        (tdiff <= PLAY_TDIFF_MAX &&
                         (bdiff == 8'd1 || bdiff == 8'd0 || bdiff == B_DOWN)))
                        reads_seen = '0;
                    else
                    begin
                        if (reads_seen < READ_COUNT_SAT)
                            reads_seen++;
                        if (reads_seen >= NON_EAR_STOP_READS)
                        begin
                            r.stop_tape = 1'b1;
                            play = 1'b0;
                            reads_seen = '0;
                            accel_mode_q = '0;
                        end
                    end
                end
                else
                begin
                    // loader reads while stopped count toward a start
                    need = '0;
                    if (it.movie_match && tdiff <= STOP_TDIFF_MAX)
                        need = MOVIE_START_READS;
                    else if (it.loop_match)
                        need = LOADER_START_READS;
                    else if (it.ear_match && tdiff <= STOP_TDIFF_MAX &&
                             (bdiff == 8'd1 || bdiff == B_DOWN))
                        need = LOADER_START_READS;
                    if (need == '0)
                        reads_seen = '0;
                    else
                    begin
                        if (reads_seen < READ_COUNT_SAT)
                            reads_seen++;
                        if (reads_seen >= need)
                        begin
                            r.start_tape = 1'b1;
                            play = 1'b1;
                            reads_seen = '0;
                            accel_mode_q = '0;
                        end
                    end
                end
                // acceleration step uses the playing state after any request
                if (acc_en && play && !rec_on)
                begin
                    if (accel_mode_q != '0 && it.instr_addr != accel_pc)
                        accel_mode_q = '0;
                    if (accel_mode_q == '0)
                    begin
                        accel_mode_q = dm;
                        accel_pc = it.instr_addr;
                    end
                    if (accel_mode_q != '0)
                    begin
                        if (cur_known)
                        begin
                            r.accel_apply = 1'b1;
                            r.accel_mode_out = accel_mode_q;
                            r.accel_long = cur_long;
                            reads_seen = '0;
                        end
                        cur_known = nxt_known;
                        cur_long = nxt_long;
                    end
                end
            end
        endcase
        return r;
    endfunction

    function automatic in_item_t rand_item();
        in_item_t it;
        it = $bits(in_item_t)'({$urandom, $urandom, $urandom});
        return it;
    endfunction

    task automatic push_item(input in_item_t it);
        pending_items.push_back(it);
        n_pushed++;
    endtask

    // Queue a read after step T-states, closing the frame when it runs over
    task automatic push_read(input in_item_t it, input int unsigned step);
        in_item_t f;
        gen_t += step;
        if (gen_t >= FRAME_TSTATES)
        begin
            f = rand_item();
            f.command = CMD_FRAME;
            f.frame_span = 17'(FRAME_TSTATES);
            push_item(f);
            gen_t -= FRAME_TSTATES;
        end
        it.command = CMD_READ;
        it.time_now = 20'(gen_t);
        push_item(it);
    endtask

    // One random stimulus sequence
    task automatic add_scenario();
        in_item_t    it;
        int          sel;
        int          n;
        logic [2:0]  mode_pick;
        logic [15:0] pc;
        sel = $urandom_range(0, 99);
        if (sel < 20)
        begin
            // loader loop seen while stopped
            n = $urandom_range(8, 13);
            repeat (n)
            begin
                it = rand_item();
                it.loop_match = 1'b1;
                it.movie_match = ($urandom_range(0, 9) == 0);
                it.tape_playing = 1'b0;
                push_read(it, $urandom_range(20, 3000));
            end
        end
        else if (sel < 30)
        begin
            // ear sampling with B stepping by one
            n = $urandom_range(8, 13);
            repeat (n)
            begin
                it = rand_item();
                it.loop_match = 1'b0;
                it.movie_match = 1'b0;
                it.ear_match = ($urandom_range(0, 15) != 0);
                it.tape_playing = 1'b0;
                if ($urandom_range(0, 15) == 0)
                    gen_b = gen_b + 8'd2;
                else
                    gen_b = gen_b + ($urandom_range(0, 1) ? 8'd1 : B_DOWN);
                it.b_value = gen_b;
                push_read(it, ($urandom_range(0, 15) == 0) ? $urandom_range(501, 900)
                                                           : $urandom_range(20, 500));
            end
        end
        else if (sel < 32)
        begin
            // long-settling loader, needs the high read count
            n = $urandom_range(120, 135);
            repeat (n)
            begin
                it = rand_item();
                it.movie_match = 1'b1;
                it.tape_playing = 1'b0;
                push_read(it, ($urandom_range(0, 31) == 0) ? $urandom_range(501, 520)
                                                           : $urandom_range(10, 500));
            end
        end
        else if (sel < 60)
        begin
            // playing: edges feed the pulse pipeline, reads at one loop address
            pc = 16'($urandom);
            mode_pick = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7))
                                                    : 3'($urandom_range(1, 5));
            n = $urandom_range(4, 12);
            repeat (n)
            begin
                it = rand_item();
                it.command = CMD_EDGE;
                it.edge_length = ($urandom_range(0, 5) == 0) ? 2'($urandom_range(0, 3))
                                                             : 2'($urandom_range(1, 2));
                it.edge_by_accel = ($urandom_range(0, 3) != 0);
                push_item(it);
                it = rand_item();
                it.loop_match = ($urandom_range(0, 7) != 0);
                it.tape_playing = 1'b1;
                if ($urandom_range(0, 9) != 0)
                begin
                    it.instr_addr = pc;
                    it.detected_mode = mode_pick;
                end
                push_read(it, $urandom_range(30, 800));
            end
        end
        else if (sel < 75)
        begin
            // non-loader reads while playing, heading for a stop
            n = $urandom_range(8, 13);
            repeat (n)
            begin
                it = rand_item();
                it.loop_match = 1'b0;
                it.movie_match = 1'b0;
                it.ear_match = 1'b0;
                it.tape_playing = 1'b1;
                push_read(it, ($urandom_range(0, 7) == 0) ? $urandom_range(10, 1000)
                                                          : $urandom_range(1001, 20000));
            end
        end
        else if (sel < 85)
        begin
            it = rand_item();
            it.command = CMD_FRAME;
            push_item(it);
            if (gen_t >= it.frame_span)
                gen_t -= it.frame_span;
        end
        else if (sel < 90)
        begin
            it = rand_item();
            it.command = CMD_PLAY;
            push_item(it);
        end
        else
        begin
            // unconstrained noise
            n = $urandom_range(1, 4);
            repeat (n)
                push_item(rand_item());
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_DETECT_ENABLE:     det_en = val;
            CFG_ACCELERATE_ENABLE: acc_en = val;
            CFG_RECORDING_ACTIVE:  rec_on = val;
            default: ;
        endcase
    endtask

    // Wait until every queued transfer is taken and every decision has come back
    task automatic drain();
        while (!(n_accepted == n_pushed && expected_decisions.size() == 0))
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Input driver: next transfer presented on the falling edge
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || s_taken))
        begin
            if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                offered_item = pending_items.pop_front();
                s_tdata <= {1'b0, offered_item.edge_by_accel, offered_item.edge_length,
                            offered_item.frame_span, offered_item.tape_playing,
                            offered_item.detected_mode, offered_item.ear_match,
                            offered_item.movie_match, offered_item.loop_match,
                            offered_item.instr_addr, offered_item.b_value,
                            offered_item.time_now};
                s_tuser <= offered_item.command;
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Result ready: random stalls plus a long hold-off on request
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Monitor: check results, predict accepted transfers
    always @(posedge clk)
    begin : monitor
        out_item_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_decisions.size() == 0)
                begin
                    $display("%0t: unexpected result, actual %h", $time, m_tdata);
                    errors++;
                end
                else
                begin
                    want = expected_decisions.pop_front();
                    check_field("stop_tape", want.stop_tape, m_tdata[0]);
                    check_field("start_tape", want.start_tape, m_tdata[1]);
                    check_field("accel_apply", want.accel_apply, m_tdata[2]);
                    check_field("accel_mode_out", want.accel_mode_out, m_tdata[5:3]);
                    check_field("accel_long", want.accel_long, m_tdata[6]);
                end
            end
            if (s_tvalid && s_tready)
            begin
                expected_decisions.push_back(tape_decision(offered_item));
                n_accepted++;
            end
            s_taken <= s_tvalid && s_tready;
        end
    end

    // Run-time limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        in_item_t it;
        int       target;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        s_taken = 1'b0;
        hold_req = 1'b0;
        hold_left = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        n_pushed = 0;
        n_accepted = 0;
        errors = 0;
        cycle_count = 0;
        gen_t = 0;
        gen_b = '0;
        // predictor reset values
        reads_seen = '0;
        last_time = NO_READ_TIME;
        last_b = '0;
        cur_known = 1'b0;
        cur_long = 1'b0;
        nxt_known = 1'b0;
        nxt_long = 1'b0;
        accel_mode_q = '0;
        accel_pc = '0;
        det_en = 1'b1;
        acc_en = 1'b1;
        rec_on = 1'b0;

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        write_reg(CFG_DETECT_ENABLE, 1'b1);
        write_reg(CFG_ACCELERATE_ENABLE, 1'b1);
        write_reg(CFG_RECORDING_ACTIVE, 1'b0);

        // Directed: frame end before any read, field extremes, every command
        it = '0;
        it.command = CMD_FRAME;
        it.frame_span = '1;
        push_item(it);
        it = '0;
        it.command = CMD_READ;
        push_item(it);
        it = '1;
        it.command = CMD_READ;
        push_item(it);
        it = '0;
        it.command = CMD_EDGE;
        it.edge_length = 2'd3;
        it.edge_by_accel = 1'b1;
        push_item(it);
        it.edge_length = 2'd0;
        it.edge_by_accel = 1'b0;
        push_item(it);
        it.edge_length = 2'd2;
        it.edge_by_accel = 1'b1;
        push_item(it);
        it.edge_length = 2'd1;
        it.edge_by_accel = 1'b0;
        push_item(it);
        it = '1;
        it.command = CMD_PLAY;
        push_item(it);
        // loader loop start while stopped
        for (int k = 0; k < 10; k++)
        begin
            it = '0;
            it.command = CMD_READ;
            it.loop_match = 1'b1;
            it.time_now = 20'(1000 + 100 * k);
            it.instr_addr = 16'h0567;
            push_item(it);
        end
        it = '0;
        it.command = CMD_EDGE;
        it.edge_length = 2'd2;
        it.edge_by_accel = 1'b1;
        push_item(it);
        // playing reads: unused mode code, then a held mode and an address change
        it = '0;
        it.command = CMD_READ;
        it.loop_match = 1'b1;
        it.tape_playing = 1'b1;
        it.instr_addr = 16'h05ed;
        it.time_now = 20'd2100;
        it.detected_mode = 3'd7;
        push_item(it);
        it.detected_mode = 3'd6;
        it.time_now = 20'd2200;
        push_item(it);
        it.detected_mode = 3'd3;
        it.time_now = 20'd2300;
        push_item(it);
        it.time_now = 20'd2400;
        push_item(it);
        it.instr_addr = 16'h05f1;
        it.detected_mode = 3'd5;
        it.time_now = 20'd2500;
        push_item(it);
        it = '0;
        it.command = CMD_FRAME;
        push_item(it);
        it.frame_span = 17'(FRAME_TSTATES);
        push_item(it);
        drain();

        // Random phases, each with its own register setting and idling mix
        for (int p = 0; p < 8; p++)
        begin
            write_reg(CFG_DETECT_ENABLE, DET_BY_PHASE[p]);
            write_reg(CFG_ACCELERATE_ENABLE, ACC_BY_PHASE[p]);
            write_reg(CFG_RECORDING_ACTIVE, REC_BY_PHASE[p]);
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 57;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 57;
                end
                default:
                begin
                    send_idle_pct = 25;
                    recv_stall_pct = 25;
                end
            endcase
            target = n_pushed + ITEMS_PER_PHASE;
            while (n_pushed < target)
                add_scenario();
            // back-pressure the result side while the sender keeps offering
            if (p == 0)
                hold_req = 1'b1;
            drain();
        end

        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/tldacc_pkg.sv
design/tldacc_core.sv
design/tape_loader_detect_accelerate_unit.sv
design/tldacc_checker.sv
sim/tb.sv
